// ===== rtl/lis_pkg.sv =====
// Shared constants and controller/datapath command and status types.
package lis_pkg;

    localparam int DEPTH_DEFAULT = 512;
    localparam int VALUE_W       = 32;
    localparam int LEN_W         = 10;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic load;     // capture the accepted word and start a new search
        logic rd_en;    // read the next stored element
        logic commit;   // store the element and load the result register
    } t_cmd;

    typedef struct packed {
        logic full;     // store holds DEPTH elements
        logic empty;    // no element stored in this sequence
        logic rd_last;  // the read being issued is of the last stored element
        logic out_busy; // result register holds a word not yet taken
    } t_status;

endpackage

// ===== rtl/lis_in_if.sv =====
// Input channel: one sequence element per word.
interface lis_in_if;
    logic                          valid;
    logic                          ready;
    logic [lis_pkg::VALUE_W-1:0]   value;
    logic                          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== rtl/lis_out_if.sv =====
// Output channel: one subsequence length per word.
interface lis_out_if;
    logic                        valid;
    logic                        ready;
    logic [lis_pkg::LEN_W-1:0]   lis_length;
    logic                        overflow;
    logic                        is_last;

    modport source (output valid, output lis_length, output overflow, output is_last,
                    input ready);
    modport sink   (input valid, input lis_length, input overflow, input is_last,
                    output ready);
endinterface

// ===== rtl/lis_ctrl.sv =====
// Controller that sequences the scan over the stored elements.
module lis_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lis_pkg::t_status i_status,
    output lis_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // No scan is needed when the store is empty or full.
                    if (i_status.full || i_status.empty) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/lis_dp.sv =====
// Datapath: element stores, scan compare, element count and result register.
module lis_dp #(
    parameter int DEPTH = lis_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lis_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_last,
    input  lis_pkg::t_cmd               i_cmd,
    output lis_pkg::t_status            o_status,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [lis_pkg::LEN_W-1:0]   o_lis_length,
    output logic                        o_overflow,
    output logic                        o_is_last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SL_W  = CNT_W;
    localparam int EXT_W = (SL_W > lis_pkg::LEN_W) ? SL_W : lis_pkg::LEN_W;
    localparam int VW    = lis_pkg::VALUE_W;

    logic [VW-1:0]   r_value_mem [DEPTH];
    logic [SL_W-1:0] r_len_mem   [DEPTH];

    logic [VW-1:0]    r_key;
    logic             r_last;
    logic [SL_W-1:0]  r_best;
    logic [IDX_W-1:0] r_j;
    logic [CNT_W-1:0] r_count;
    logic             r_rd_vld;
    logic [VW-1:0]    r_rd_val;
    logic [SL_W-1:0]  r_rd_len;
    logic             r_out_vld;

    logic             full;
    logic [EXT_W-1:0] best_ext;

    assign full     = (r_count == CNT_W'(DEPTH));
    assign best_ext = EXT_W'(r_best);

    assign o_status.full     = full;
    assign o_status.empty    = (r_count == '0);
    assign o_status.rd_last  = ((CNT_W'(r_j) + CNT_W'(1)) == r_count);
    assign o_status.out_busy = r_out_vld && !i_out_ready;

    // Stores are read one element a cycle during the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_val <= r_value_mem[r_j];
            r_rd_len <= r_len_mem[r_j];
        end
        if (i_cmd.commit && !full) begin
            r_value_mem[r_count[IDX_W-1:0]] <= r_key;
            r_len_mem[r_count[IDX_W-1:0]]   <= r_best;
        end
    end

    // Keys are kept with the sign bit flipped so that unsigned order is signed order.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_value ^ {1'b1, {(VW-1){1'b0}}};
            r_last <= i_last;
            r_best <= SL_W'(1);
            r_j    <= '0;
        end else begin
            if (i_cmd.rd_en) begin
                r_j <= r_j + IDX_W'(1);
            end
            if (r_rd_vld && (r_rd_val < r_key) && (r_rd_len >= r_best)) begin
                r_best <= r_rd_len + SL_W'(1);
            end
        end
        if (i_cmd.commit) begin
            o_overflow <= full;
            o_is_last  <= r_last;
            if (full) begin
                o_lis_length <= '0;
            end else if (best_ext > EXT_W'(lis_pkg::LEN_MAX)) begin
                o_lis_length <= lis_pkg::LEN_MAX;
            end else begin
                o_lis_length <= best_ext[lis_pkg::LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
                if (r_last) begin
                    r_count <= '0;
                end else if (!full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// ===== rtl/lis_length_per_element_top.sv =====
// Top level of the per-element longest increasing subsequence block.
//
// Each input word carries a signed 32-bit element; the block answers with the
// length of the longest strictly increasing subsequence ending at that element,
// comparing it against every element stored earlier in the same sequence. The
// scan reads one stored element per cycle from the element store, over the N
// elements already stored (at most DEPTH - 1); the result register is then
// loaded after a drain state, or directly when the store is empty or full,
// once the result register no longer holds a word not yet taken. The next
// word can be accepted in the cycle after the result is loaded. A full store
// gives length 0 with overflow set. A word marked last ends the sequence. The
// result register lets the next word be accepted while a result still waits
// to be taken.
module lis_length_per_element_top #(
    parameter int DEPTH = lis_pkg::DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lis_in_if.sink    i_in,
    lis_out_if.source o_out
);

    lis_pkg::t_cmd    cmd;
    lis_pkg::t_status status;

    lis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lis_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_in.value),
        .i_last       (i_in.last),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_lis_length (o_out.lis_length),
        .o_overflow   (o_out.overflow),
        .o_is_last    (o_out.is_last)
    );

endmodule
